>>> sv/quadrature_nco_mixer_core_assert.svh
// Assertion macros used by the quadrature NCO mixer control module.
`ifndef QUADRATURE_NCO_MIXER_CORE_ASSERT_SVH
`define QUADRATURE_NCO_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QNM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QNM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/qnm_pkg.sv
`timescale 1ns / 1ps

package qnm_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int PHASE_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int MUL_WIDTH       = 17;
   localparam int PRODUCT_WIDTH   = 2 * MUL_WIDTH;
   localparam int MIX_SHIFT       = 15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_STEP  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUAD_OFFSET = CSR_INDEX_WIDTH'(1);

   localparam logic [PHASE_WIDTH-1:0] PHASE_STEP_RESET  = 16'd0;
   localparam logic [PHASE_WIDTH-1:0] QUAD_OFFSET_RESET = 16'd16384;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic load;
      logic interp_i;
      logic interp_q;
      logic mix_i;
      logic mix_q;
      logic finish;
   } qnm_cmd_type;

   // Product of two Q60 values, kept in Q60.
   function automatic logic [63:0] q60_mul(
      input logic [63:0] a,
      input logic [63:0] b
   );
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[123:60];
   endfunction

   // Position of a full-period table entry within the first quadrant.
   function automatic logic [63:0] sine_fold(
      input int unsigned index_bits,
      input int unsigned entry
   );
      logic [63:0] n;
      logic [63:0] q;
      logic [63:0] j;
      logic [63:0] k;
      n = 64'd1 << index_bits;
      q = n >> 2;
      j = 64'(entry) & (n - 64'd1);
      if (j <= q) begin
         k = j;
      end else if (j <= 2 * q) begin
         k = 2 * q - j;
      end else if (j <= 3 * q) begin
         k = j - 2 * q;
      end else begin
         k = 4 * q - j;
      end
      return k;
   endfunction

   // True where a table entry lies in the lower half of the period.
   function automatic logic sine_negative(
      input int unsigned index_bits,
      input int unsigned entry
   );
      logic [63:0] n;
      logic [63:0] q;
      logic [63:0] j;
      n = 64'd1 << index_bits;
      q = n >> 2;
      j = 64'(entry) & (n - 64'd1);
      return (j > 2 * q);
   endfunction

   // A Q60 first-quadrant sine rounded to Q15 and given its sign.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sine_round(
      input logic [63:0] sum,
      input logic        neg
   );
      logic [63:0]                    mag;
      logic signed [SAMPLE_WIDTH-1:0] value;
      mag   = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
      value = SAMPLE_WIDTH'(mag);
      return neg ? -value : value;
   endfunction

endpackage

>>> sv/qnm_ctrl.sv
`timescale 1ns / 1ps
`include "quadrature_nco_mixer_core_assert.svh"

module qnm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qnm_pkg::qnm_cmd_type cmd
);
   import qnm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_INTERP_I = 6'b000010,
      ST_INTERP_Q = 6'b000100,
      ST_MIX_I    = 6'b001000,
      ST_MIX_Q    = 6'b010000,
      ST_FINISH   = 6'b100000
   } qnm_state_type;

   qnm_state_type state_ff;
   qnm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          slot_free;
   logic          accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && slot_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_INTERP_I;
            end
         end
         ST_INTERP_I: state_in = ST_INTERP_Q;
         ST_INTERP_Q: state_in = ST_MIX_I;
         ST_MIX_I:    state_in = ST_MIX_Q;
         ST_MIX_Q:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = accept ? ST_INTERP_I : ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if ((state_ff == ST_FINISH) && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cmd.load     = accept;
      cmd.interp_i = (state_ff == ST_INTERP_I);
      cmd.interp_q = (state_ff == ST_INTERP_Q);
      cmd.mix_i    = (state_ff == ST_MIX_I);
      cmd.mix_q    = (state_ff == ST_MIX_Q);
      cmd.finish   = (state_ff == ST_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `QNM_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_INTERP_I, "accepted beat did not start the datapath sequence")
   `QNM_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff == ST_INTERP_I || state_ff == ST_INTERP_Q || state_ff == ST_MIX_I || state_ff == ST_MIX_Q, !req_ready, "input ready while the datapath is busy")
   `QNM_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "result beat appeared without a finish step")
   `QNM_ASSERT_NEXT(a_finish_holds, clock, reset, state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready, state_ff == ST_FINISH, "finish step left while the output was full")

endmodule

>>> sv/qnm_datapath.sv
`timescale 1ns / 1ps

module qnm_datapath #(
   parameter int TABLE_INDEX_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  qnm_pkg::qnm_cmd_type                      cmd,
   input  logic                                      csr_valid,
   input  logic        [qnm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [qnm_pkg::PHASE_WIDTH-1:0]     csr_wdata,
   input  logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    req_sample,
   output logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    rsp_in_phase,
   output logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    rsp_quadrature
);
   import qnm_pkg::*;

   localparam int FRAC_BITS = PHASE_WIDTH - TABLE_INDEX_BITS;
   localparam int TABLE_LEN = (1 << TABLE_INDEX_BITS) + 1;

   logic signed [SAMPLE_WIDTH-1:0]  sine_rom [TABLE_LEN];

   // Each entry is a Q60 Taylor series of the first quadrant, rounded to Q15.
   for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
      localparam logic [63:0] K   = sine_fold(TABLE_INDEX_BITS, g);
      localparam logic [63:0] X   = (PI_Q60 >> (TABLE_INDEX_BITS - 1)) * K;
      localparam logic [63:0] X2  = q60_mul(X, X);
      localparam logic [63:0] T1  = q60_mul(X, X2) / 64'd6;
      localparam logic [63:0] T2  = q60_mul(T1, X2) / 64'd20;
      localparam logic [63:0] T3  = q60_mul(T2, X2) / 64'd42;
      localparam logic [63:0] T4  = q60_mul(T3, X2) / 64'd72;
      localparam logic [63:0] T5  = q60_mul(T4, X2) / 64'd110;
      localparam logic [63:0] T6  = q60_mul(T5, X2) / 64'd156;
      localparam logic [63:0] T7  = q60_mul(T6, X2) / 64'd210;
      localparam logic [63:0] T8  = q60_mul(T7, X2) / 64'd272;
      localparam logic [63:0] T9  = q60_mul(T8, X2) / 64'd342;
      localparam logic [63:0] T10 = q60_mul(T9, X2) / 64'd420;
      localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;
      localparam logic NEG = sine_negative(TABLE_INDEX_BITS, g);
      localparam logic signed [SAMPLE_WIDTH-1:0] ENTRY = sine_round(SUM, NEG);
      assign sine_rom[g] = ENTRY;
   end

   logic        [PHASE_WIDTH-1:0]    phase_step_ff;
   logic        [PHASE_WIDTH-1:0]    quad_offset_ff;
   logic        [PHASE_WIDTH-1:0]    phase_acc_ff;
   logic        [PHASE_WIDTH-1:0]    phase_i_ff;
   logic        [PHASE_WIDTH-1:0]    phase_q_ff;
   logic signed [SAMPLE_WIDTH-1:0]   sample_ff;
   logic signed [SAMPLE_WIDTH-1:0]   base_ff;
   logic signed [SAMPLE_WIDTH-1:0]   osc_i_ff;
   logic signed [SAMPLE_WIDTH-1:0]   osc_q_ff;
   logic signed [SAMPLE_WIDTH-1:0]   in_phase_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rsp_in_phase_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rsp_quadrature_ff;
   logic signed [PRODUCT_WIDTH-1:0]  prod_ff;
   logic signed [PRODUCT_WIDTH-1:0]  prod_in;

   logic        [PHASE_WIDTH-1:0]      look_phase;
   logic        [TABLE_INDEX_BITS:0]   idx_lo;
   logic        [TABLE_INDEX_BITS:0]   idx_hi;
   logic        [FRAC_BITS-1:0]        frac;
   logic signed [SAMPLE_WIDTH-1:0]     entry_lo;
   logic signed [SAMPLE_WIDTH-1:0]     entry_hi;
   logic signed [MUL_WIDTH-1:0]        diff;
   logic signed [MUL_WIDTH-1:0]        mul_a;
   logic signed [MUL_WIDTH-1:0]        mul_b;
   logic signed [PRODUCT_WIDTH-1:0]    osc_wide;
   logic signed [SAMPLE_WIDTH-1:0]     osc_next;
   logic                               mul_en;

   assign look_phase = cmd.interp_q ? phase_q_ff : phase_i_ff;
   assign idx_lo     = {1'b0, look_phase[PHASE_WIDTH-1 -: TABLE_INDEX_BITS]};
   assign idx_hi     = idx_lo + 1'b1;
   assign frac       = look_phase[FRAC_BITS-1:0];
   assign entry_lo   = sine_rom[idx_lo];
   assign entry_hi   = sine_rom[idx_hi];
   assign diff       = MUL_WIDTH'(entry_hi) - MUL_WIDTH'(entry_lo);

   always_comb begin
      mul_a = diff;
      mul_b = signed'(MUL_WIDTH'({1'b0, frac}));
      if (cmd.mix_i) begin
         mul_a = MUL_WIDTH'(sample_ff);
         mul_b = MUL_WIDTH'(osc_i_ff);
      end else if (cmd.mix_q) begin
         mul_a = MUL_WIDTH'(sample_ff);
         mul_b = MUL_WIDTH'(osc_q_ff);
      end
   end

   assign prod_in  = mul_a * mul_b;
   assign mul_en   = cmd.interp_i || cmd.interp_q || cmd.mix_i || cmd.mix_q;
   assign osc_wide = PRODUCT_WIDTH'(base_ff) + (prod_ff >>> FRAC_BITS);
   assign osc_next = osc_wide[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RESET;
         quad_offset_ff <= QUAD_OFFSET_RESET;
         phase_acc_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_PHASE_STEP:  phase_step_ff  <= csr_wdata;
               CSR_QUAD_OFFSET: quad_offset_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            phase_acc_ff <= phase_acc_ff + phase_step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff  <= req_sample;
         phase_i_ff <= phase_acc_ff;
         phase_q_ff <= phase_acc_ff + quad_offset_ff;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.interp_i || cmd.interp_q) begin
         base_ff <= entry_lo;
      end
      if (cmd.interp_q) begin
         osc_i_ff <= osc_next;
      end
      if (cmd.mix_i) begin
         osc_q_ff <= osc_next;
      end
      if (cmd.mix_q) begin
         in_phase_ff <= prod_ff[MIX_SHIFT +: SAMPLE_WIDTH];
      end
      if (cmd.finish) begin
         rsp_in_phase_ff   <= in_phase_ff;
         rsp_quadrature_ff <= prod_ff[MIX_SHIFT +: SAMPLE_WIDTH];
      end
   end

   assign rsp_in_phase   = rsp_in_phase_ff;
   assign rsp_quadrature = rsp_quadrature_ff;

endmodule

>>> sv/quadrature_nco_mixer_core.sv
// Steps INTERP_I, INTERP_Q, MIX_I, MIX_Q, FINISH follow an accepted sample; a
// new sample is taken only when idle or in FINISH. The four products of an
// item (two interpolations, two mixes) pass in turn through one shared 17x17
// multiplier; FINISH waits for a free output and moves the pair into it.
// Reset (synchronous): phase accumulator 0, phase_step 0, quad_offset 16384,
// no result pending. The sine table is a constant and needs no fill.
`timescale 1ns / 1ps

module quadrature_nco_mixer_core #(
   parameter int TABLE_INDEX_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    rsp_in_phase,
   output logic signed [qnm_pkg::SAMPLE_WIDTH-1:0]    rsp_quadrature,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [qnm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [qnm_pkg::PHASE_WIDTH-1:0]     csr_wdata
);
   import qnm_pkg::*;

   qnm_cmd_type cmd;

   assign csr_ready = 1'b1;

   qnm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   qnm_datapath #(
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_sample),
      .rsp_in_phase   (rsp_in_phase),
      .rsp_quadrature (rsp_quadrature)
   );

endmodule
